>>> hw/rtl/bse_pkg.sv
// Shared types and codes for the bounded stack engine.
// No dependencies.
package bse_pkg;

    localparam logic [2:0] KIND_PUSH    = 3'd0;
    localparam logic [2:0] KIND_POP     = 3'd1;
    localparam logic [2:0] KIND_PEEK    = 3'd2;
    localparam logic [2:0] KIND_CHANGE  = 3'd3;
    localparam logic [2:0] KIND_DISPLAY = 3'd4;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [1:0] STATUS_EMPTY    = 2'd2;
    localparam logic [1:0] STATUS_INVALID  = 2'd3;

    localparam int WORD_W = 32;
    localparam int POS_W  = 4;

    typedef struct packed {
        logic [2:0]              kind;
        logic signed [WORD_W-1:0] value;
        logic [POS_W-1:0]        position;
    } t_req;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [WORD_W-1:0] data;
        logic                    last;
    } t_rsp;

endpackage

>>> hw/rtl/bse_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/bounded_stack_engine.sv
// Bounded LIFO stack engine: request decode, stack pointer, result register.
// Depends on bse_pkg and bse_ram.
//
// Usage:
//   Requests enter on i_in_valid / i_in_data / o_in_stall; results leave on
//   o_out_valid / o_out_data / i_out_stall. A transfer happens on a rising edge
//   with valid high and stall low.
//   Push, change and every error result appear in the cycle after the request
//   transfer; the block takes a new request every cycle for these while the
//   receiver does not stall. Pop and peek read the entry memory (registered
//   read data), so their result passes the RAM read register and then the
//   result register; the next request is taken once the block is idle again.
//   Display reads the memory from top to bottom, one entry per cycle while the
//   receiver does not stall; the bottom entry carries last.
//   Unknown request kinds are dropped with no result.
//   A request is taken only when idle and the result register is empty or
//   draining. When the receiver stalls, the result register holds and the
//   display stream pauses in place.
//   Reset empties the stack and the result register; entry contents are left
//   as they are and are never returned in a result before being written.
module bounded_stack_engine #(
    parameter int DEPTH = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  bse_pkg::t_req   i_in_data,
    output logic            o_in_stall,
    output logic            o_out_valid,
    output bse_pkg::t_rsp   o_out_data,
    input  logic            i_out_stall
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > bse_pkg::POS_W) ? CW : bse_pkg::POS_W;

    typedef enum logic {
        S_IDLE,
        S_STREAM
    } t_state;

    t_state                       r_state, n_state;
    logic [CW-1:0]                r_count, n_count;
    logic [AW-1:0]                r_idx, n_idx;
    logic                         r_single, n_single;
    logic                         r_out_valid, n_out_valid;
    bse_pkg::t_rsp                r_out_data, n_out_data;

    logic                         out_free;
    logic                         accept;
    logic                         full;
    logic                         empty;
    logic                         pos_ok;
    logic [PW-1:0]                pos_ext;
    logic [PW-1:0]                count_ext;
    logic [AW-1:0]                top_addr;
    logic                         load;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [bse_pkg::WORD_W-1:0]   ram_wdata;
    logic [AW-1:0]                ram_raddr;
    logic [bse_pkg::WORD_W-1:0]   ram_rdata;

    bse_ram #(
        .WIDTH (bse_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign accept     = i_in_valid && !o_in_stall;

    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);
    assign pos_ext   = PW'(i_in_data.position);
    assign count_ext = PW'(r_count);
    assign pos_ok    = (pos_ext != '0) && (pos_ext <= count_ext);
    assign top_addr  = AW'(r_count - CW'(1));
    assign load      = (r_state == S_STREAM) && out_free;

    always_comb begin
        ram_raddr = top_addr;
        if (r_state == S_STREAM) begin
            ram_raddr = (load && (r_idx != '0)) ? (r_idx - AW'(1)) : r_idx;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_single    = r_single;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        ram_waddr   = AW'(r_count);
        ram_wdata   = i_in_data.value;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out_data.data = '0;
                    n_out_data.last = 1'b1;
                    unique case (i_in_data.kind)
                        bse_pkg::KIND_PUSH: begin
                            n_out_valid = 1'b1;
                            if (full) begin
                                n_out_data.status = bse_pkg::STATUS_OVERFLOW;
                            end else begin
                                n_out_data.status = bse_pkg::STATUS_OK;
                                ram_we            = 1'b1;
                                n_count           = r_count + CW'(1);
                            end
                        end
                        bse_pkg::KIND_POP, bse_pkg::KIND_PEEK,
                        bse_pkg::KIND_DISPLAY: begin
                            if (empty) begin
                                n_out_valid       = 1'b1;
                                n_out_data.status = bse_pkg::STATUS_EMPTY;
                            end else begin
                                n_state  = S_STREAM;
                                n_idx    = top_addr;
                                n_single = (i_in_data.kind != bse_pkg::KIND_DISPLAY);
                                if (i_in_data.kind == bse_pkg::KIND_POP) begin
                                    n_count = r_count - CW'(1);
                                end
                            end
                        end
                        bse_pkg::KIND_CHANGE: begin
                            n_out_valid = 1'b1;
                            if (empty) begin
                                n_out_data.status = bse_pkg::STATUS_EMPTY;
                            end else if (!pos_ok) begin
                                n_out_data.status = bse_pkg::STATUS_INVALID;
                            end else begin
                                n_out_data.status = bse_pkg::STATUS_OK;
                                ram_we            = 1'b1;
                                ram_waddr         = AW'(pos_ext - PW'(1));
                            end
                        end
                        default: begin
                            n_out_data = r_out_data;
                        end
                    endcase
                end
            end
            S_STREAM: begin
                if (load) begin
                    n_out_valid       = 1'b1;
                    n_out_data.status = bse_pkg::STATUS_OK;
                    n_out_data.data   = ram_rdata;
                    n_out_data.last   = r_single || (r_idx == '0);
                    if (r_single || (r_idx == '0)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx - AW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_idx      <= n_idx;
        r_single   <= n_single;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> tb/sv/stack_check_pkg.sv
// Scoreboard for the bounded stack engine: predicts results from accepted requests.
// Depends on bse_pkg for the request and result types and codes.
package stack_check_pkg;

    localparam int STACK_DEPTH = 8;

    class stack_scoreboard;
        logic signed [bse_pkg::WORD_W-1:0] slots [STACK_DEPTH];
        int unsigned                       used;
        bse_pkg::t_rsp                     expected_q [$];
        int unsigned                       mismatch_count;

        function new();
            used = 0;
            mismatch_count = 0;
        endfunction

        function void queue_rsp(logic [1:0] status, logic signed [bse_pkg::WORD_W-1:0] data,
                                logic is_last);
            bse_pkg::t_rsp rsp;
            rsp.status = status;
            rsp.data   = data;
            rsp.last   = is_last;
            expected_q.push_back(rsp);
        endfunction

        function void note_request(bse_pkg::t_req req);
            case (req.kind)
                bse_pkg::KIND_PUSH: begin
                    if (used == STACK_DEPTH) begin
                        queue_rsp(bse_pkg::STATUS_OVERFLOW, '0, 1'b1);
                    end else begin
                        slots[used] = req.value;
                        used++;
                        queue_rsp(bse_pkg::STATUS_OK, '0, 1'b1);
                    end
                end
                bse_pkg::KIND_POP: begin
                    if (used == 0) begin
                        queue_rsp(bse_pkg::STATUS_EMPTY, '0, 1'b1);
                    end else begin
                        used--;
                        queue_rsp(bse_pkg::STATUS_OK, slots[used], 1'b1);
                    end
                end
                bse_pkg::KIND_PEEK: begin
                    if (used == 0) begin
                        queue_rsp(bse_pkg::STATUS_EMPTY, '0, 1'b1);
                    end else begin
                        queue_rsp(bse_pkg::STATUS_OK, slots[used-1], 1'b1);
                    end
                end
                bse_pkg::KIND_CHANGE: begin
                    if (used == 0) begin
                        queue_rsp(bse_pkg::STATUS_EMPTY, '0, 1'b1);
                    end else if (req.position < 1 || req.position > used) begin
                        queue_rsp(bse_pkg::STATUS_INVALID, '0, 1'b1);
                    end else begin
                        slots[req.position-1] = req.value;
                        queue_rsp(bse_pkg::STATUS_OK, '0, 1'b1);
                    end
                end
                bse_pkg::KIND_DISPLAY: begin
                    if (used == 0) begin
                        queue_rsp(bse_pkg::STATUS_EMPTY, '0, 1'b1);
                    end else begin
                        for (int i = used; i > 0; i--) begin
                            queue_rsp(bse_pkg::STATUS_OK, slots[i-1], i == 1);
                        end
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void check_result(bse_pkg::t_rsp got);
            bse_pkg::t_rsp want;
            if (expected_q.size() == 0) begin
                $error("result with nothing pending: status %0d data %0d last %0d",
                       got.status, got.data, got.last);
                mismatch_count++;
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatch_count++;
            end
            if (got.data !== want.data) begin
                $error("data: expected %0d, got %0d", want.data, got.data);
                mismatch_count++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                mismatch_count++;
            end
        endfunction
    endclass

endpackage

>>> tb/sv/tb.sv
// Top-level bench for bounded_stack_engine: directed and random stack requests
// with random idle and stall on both channels. Depends on bse_pkg and stack_check_pkg.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT       = 23;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 456;
    localparam int DRAIN_CYCLES   = 40;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    bse_pkg::t_req i_in_data   = '0;
    logic          o_in_stall;
    logic          o_out_valid;
    bse_pkg::t_rsp o_out_data;
    logic          i_out_stall = 1'b0;

    bit                               quiet     = 1'b0;
    int unsigned                      gen_depth = 0;
    stack_check_pkg::stack_scoreboard sb;

    always #5 i_clk = ~i_clk;

    bounded_stack_engine #(
        .DEPTH(stack_check_pkg::STACK_DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_out_stall(i_out_stall)
    );

    always @(posedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(o_out_data);
            end
            if (i_in_valid && !o_in_stall) begin
                sb.note_request(i_in_data);
            end
        end
    end

    initial begin : watchdog
        int unsigned dry;
        dry = 0;
        while (dry < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                dry = 0;
            end else begin
                dry++;
            end
        end
        $display("TB_ERROR");
        $finish;
    end

    function automatic bse_pkg::t_req make_req(logic [2:0] kind,
                                               logic signed [bse_pkg::WORD_W-1:0] value,
                                               logic [bse_pkg::POS_W-1:0] position);
        bse_pkg::t_req req;
        req.kind     = kind;
        req.value    = value;
        req.position = position;
        return req;
    endfunction

    task automatic send_request(input bse_pkg::t_req req);
        int unsigned gap;
        gap = 0;
        while (!quiet && ($urandom_range(99) < IDLE_PCT)) begin
            gap++;
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        if (req.kind == bse_pkg::KIND_PUSH && gen_depth < stack_check_pkg::STACK_DEPTH) begin
            gen_depth++;
        end else if (req.kind == bse_pkg::KIND_POP && gen_depth > 0) begin
            gen_depth--;
        end
    endtask

    task automatic random_request(input bit fill_bias);
        int unsigned                       roll;
        logic [2:0]                        kind;
        logic signed [bse_pkg::WORD_W-1:0] value;
        logic [bse_pkg::POS_W-1:0]         position;
        roll = $urandom_range(99);
        if (roll < (fill_bias ? 45 : 12)) begin
            kind = bse_pkg::KIND_PUSH;
        end else if (roll < 52) begin
            kind = bse_pkg::KIND_POP;
        end else if (roll < 62) begin
            kind = bse_pkg::KIND_PEEK;
        end else if (roll < 78) begin
            kind = bse_pkg::KIND_CHANGE;
        end else if (roll < 94) begin
            kind = bse_pkg::KIND_DISPLAY;
        end else begin
            kind = 3'($urandom_range(7, 5));
        end
        if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
                0: value = 32'sh7FFF_FFFF;
                1: value = 32'sh8000_0000;
                2: value = -32'sd1;
                default: value = '0;
            endcase
        end else begin
            value = $urandom;
        end
        if (kind == bse_pkg::KIND_CHANGE && gen_depth > 0 && $urandom_range(99) < 70) begin
            position = bse_pkg::POS_W'($urandom_range(gen_depth, 1));
        end else begin
            position = bse_pkg::POS_W'($urandom_range(15));
        end
        send_request(make_req(kind, value, position));
    endtask

    initial begin
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(make_req(bse_pkg::KIND_PEEK, '0, 4'd0));
        send_request(make_req(bse_pkg::KIND_POP, '0, 4'd0));
        send_request(make_req(bse_pkg::KIND_CHANGE, 32'sd7, 4'd1));
        send_request(make_req(bse_pkg::KIND_DISPLAY, '0, 4'd0));
        send_request(make_req(bse_pkg::KIND_PUSH, 32'sh7FFF_FFFF, 4'd0));
        send_request(make_req(bse_pkg::KIND_PUSH, 32'sh8000_0000, 4'd15));
        send_request(make_req(bse_pkg::KIND_PUSH, -32'sd1, 4'd0));
        send_request(make_req(bse_pkg::KIND_PUSH, '0, 4'd0));
        for (int k = 0; k < stack_check_pkg::STACK_DEPTH - 4; k++) begin
            send_request(make_req(bse_pkg::KIND_PUSH, $urandom,
                                  bse_pkg::POS_W'($urandom_range(15))));
        end
        send_request(make_req(bse_pkg::KIND_PUSH, 32'sd99, 4'd0));
        send_request(make_req(bse_pkg::KIND_CHANGE, 32'sd11, 4'd0));
        send_request(make_req(bse_pkg::KIND_CHANGE, 32'sd12, 4'd15));
        send_request(make_req(bse_pkg::KIND_CHANGE, 32'sh8000_0000, 4'd8));
        send_request(make_req(bse_pkg::KIND_CHANGE, 32'sh7FFF_FFFF, 4'd1));
        send_request(make_req(bse_pkg::KIND_PEEK, '0, 4'd0));
        send_request(make_req(bse_pkg::KIND_DISPLAY, '0, 4'd0));
        send_request(make_req(3'd5, 32'sd1, 4'd1));
        send_request(make_req(3'd7, -32'sd1, 4'd15));
        send_request(make_req(bse_pkg::KIND_POP, '0, 4'd0));
        send_request(make_req(bse_pkg::KIND_CHANGE, 32'sd5, 4'd8));
        send_request(make_req(bse_pkg::KIND_DISPLAY, '0, 4'd0));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet = (n >= 200 && n < 300);
            random_request(((n / 32) % 2) == 0);
        end
        quiet = 1'b0;
        i_in_valid <= 1'b0;
        @(posedge i_clk);

        while (sb.expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatch_count == 0 && sb.expected_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
